>>> src/dkp_pkg.sv
// Shared types, register map and constants of the distance-keeping PID controller.
`timescale 1ns / 1ps

package dkp_pkg;

    // Register map, one 32-bit word per register.
    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_KP    = 3'd0;
    localparam logic [2:0] REG_KI    = 3'd1;
    localparam logic [2:0] REG_KD    = 3'd2;
    localparam logic [2:0] REG_FLOOR = 3'd3;
    localparam logic [2:0] REG_CEIL  = 3'd4;
    localparam logic [2:0] REG_KEEP  = 3'd5;
    localparam logic [2:0] REG_BAND  = 3'd6;

    // Reset values of the registers (Q16.16).
    localparam logic signed [31:0] KP_RESET    = 32'sd196608;
    localparam logic signed [31:0] KI_RESET    = 32'sd3277;
    localparam logic signed [31:0] KD_RESET    = 32'sd13107;
    localparam logic signed [31:0] FLOOR_RESET = -32'sd19661;
    localparam logic signed [31:0] CEIL_RESET  = 32'sd131072;
    localparam logic [30:0]        KEEP_RESET  = 31'd131072;
    localparam logic [30:0]        BAND_RESET  = 31'd6554;

    // Input kinds carried on tuser.
    localparam logic KIND_ODOMETRY = 1'b0;
    localparam logic KIND_TARGET   = 1'b1;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Iteration counts of the square root and the divider.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 64;
    localparam int STEP_CNT_W = 6;

    // Saturation limits.
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Configuration as seen by the back end.
    typedef struct packed {
        logic signed [31:0] kp;
        logic signed [31:0] ki;
        logic signed [31:0] kd;
        logic signed [31:0] floor_lim;
        logic signed [31:0] ceil_lim;
        logic [30:0]        keep;
        logic [30:0]        band;
    } dkp_cfg_t;

    // One target job queued for the back end.
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] speed;
        logic [31:0]        dt;
    } dkp_job_t;

    localparam int JOB_W = $bits(dkp_job_t);

    // Magnitude of a 33-bit signed value.
    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : 33'(v);
        return m;
    endfunction

    // Magnitude of a 32-bit signed value.
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : 32'(v);
        return m;
    endfunction

endpackage

>>> src/distance_keeping_pid_controller.sv
// Top level of the distance-keeping PID controller: register port and the two ends.
`timescale 1ns / 1ps

// Usage:
// Input words arrive on the s_axis channel; tuser[0] is req_type. An
// odometry word (req_type 0) stores x, y and speed and gives no
// output word. A target word (req_type 1) is queued (two entries) and gives
// one output word on m_axis: tdata is the throttle, tuser[0] stopped and
// tuser[1] no_elapsed.
// In the back end a target word goes through a square root and, with nonzero
// elapsed time, a divider, one result bit each per cycle, around one shared
// 33x33 multiplier; the PID step is skipped when the error falls in the stop
// band. Words are worked on one at a time; the queue keeps accepting while
// one is in work. A finished word waits in the output register while the
// back end goes on to the next job; when both are blocked, s_axis_tready
// drops once the queue is full.
// Reset clears the vehicle state, integrator, previous error, queue and
// output, and loads the default gains and limits. The user must write registers
// through the APB port only while the block is idle; the block does not enforce this.

module distance_keeping_pid_controller
    import dkp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [127:0]          s_axis_tdata,   // coord_x, coord_y, vehicle_speed, elapsed_time
    input  logic [0:0]            s_axis_tuser,   // req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // throttle
    output logic [1:0]            m_axis_tuser,   // stopped, no_elapsed
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    dkp_cfg_t cfg_reg, cfg_next;
    logic     cfg_write;
    logic     push, pop, q_full, q_empty;
    dkp_job_t push_job, pop_job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (paddr[CFG_ADDR_W-1:2])
                REG_KP:    cfg_next.kp        = pwdata;
                REG_KI:    cfg_next.ki        = pwdata;
                REG_KD:    cfg_next.kd        = pwdata;
                REG_FLOOR: cfg_next.floor_lim = pwdata;
                REG_CEIL:  cfg_next.ceil_lim  = pwdata;
                REG_KEEP:  cfg_next.keep      = pwdata[30:0];
                REG_BAND:  cfg_next.band      = pwdata[30:0];
                default:   cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp        <= KP_RESET;
            cfg_reg.ki        <= KI_RESET;
            cfg_reg.kd        <= KD_RESET;
            cfg_reg.floor_lim <= FLOOR_RESET;
            cfg_reg.ceil_lim  <= CEIL_RESET;
            cfg_reg.keep      <= KEEP_RESET;
            cfg_reg.band      <= BAND_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register reads.
    always_comb
    begin
        unique case (paddr[CFG_ADDR_W-1:2])
            REG_KP:    prdata = cfg_reg.kp;
            REG_KI:    prdata = cfg_reg.ki;
            REG_KD:    prdata = cfg_reg.kd;
            REG_FLOOR: prdata = cfg_reg.floor_lim;
            REG_CEIL:  prdata = cfg_reg.ceil_lim;
            REG_KEEP:  prdata = {1'b0, cfg_reg.keep};
            REG_BAND:  prdata = {1'b0, cfg_reg.band};
            default:   prdata = '0;
        endcase
    end

    dkp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (q_full),
        .push          (push),
        .push_job      (push_job)
    );

    dkp_fifo #(.WIDTH(JOB_W)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (pop_job),
        .full      (q_full),
        .empty     (q_empty)
    );

    dkp_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .queue_empty   (q_empty),
        .queue_job     (pop_job),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> src/dkp_fifo.sv
// Short register queue between the front and back of the controller.
`timescale 1ns / 1ps

module dkp_fifo
    import dkp_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/dkp_front.sv
// Front end: accepts words, applies odometry and queues target jobs.
`timescale 1ns / 1ps

module dkp_front
    import dkp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [127:0]   s_axis_tdata,   // coord_x, coord_y, vehicle_speed, elapsed_time
    input  logic [0:0]     s_axis_tuser,   // req_type
    input  logic           queue_full,
    output logic           push,
    output dkp_job_t       push_job
);

    logic signed [31:0] coord_x, coord_y, speed_in;
    logic [31:0]        dt_in;
    logic               accept;

    logic signed [31:0] veh_x_reg, veh_x_next;
    logic signed [31:0] veh_y_reg, veh_y_next;
    logic signed [31:0] veh_speed_reg, veh_speed_next;

    assign coord_x  = s_axis_tdata[31:0];
    assign coord_y  = s_axis_tdata[63:32];
    assign speed_in = s_axis_tdata[95:64];
    assign dt_in    = s_axis_tdata[127:96];

    assign s_axis_tready = !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept && (s_axis_tuser[0] == KIND_TARGET);

    // Target jobs carry the offset to the target, the stored speed and the elapsed time.
    always_comb
    begin
        push_job.dx    = {coord_x[31], coord_x} - {veh_x_reg[31], veh_x_reg};
        push_job.dy    = {coord_y[31], coord_y} - {veh_y_reg[31], veh_y_reg};
        push_job.speed = veh_speed_reg;
        push_job.dt    = dt_in;
    end

    // Odometry words update the vehicle state and retire here.
    always_comb
    begin
        veh_x_next     = veh_x_reg;
        veh_y_next     = veh_y_reg;
        veh_speed_next = veh_speed_reg;
        if (accept && (s_axis_tuser[0] == KIND_ODOMETRY))
        begin
            veh_x_next     = coord_x;
            veh_y_next     = coord_y;
            veh_speed_next = speed_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            veh_x_reg     <= '0;
            veh_y_reg     <= '0;
            veh_speed_reg <= '0;
        end
        else
        begin
            veh_x_reg     <= veh_x_next;
            veh_y_reg     <= veh_y_next;
            veh_speed_reg <= veh_speed_next;
        end
    end

endmodule

>>> src/dkp_back.sv
// Back end: distance, stop band and PID sequencer with shared multiplier.
`timescale 1ns / 1ps

module dkp_back
    import dkp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  dkp_cfg_t     cfg,
    input  logic         queue_empty,
    input  dkp_job_t     queue_job,
    output logic         pop,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // throttle
    output logic [1:0]   m_axis_tuser    // stopped, no_elapsed
);

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_SQX   = 18'h00002,
        S_SQY   = 18'h00004,
        S_SUM   = 18'h00008,
        S_SQRT  = 18'h00010,
        S_ERR   = 18'h00020,
        S_BAND  = 18'h00040,
        S_PMUL  = 18'h00080,
        S_IMUL  = 18'h00100,
        S_ILO   = 18'h00200,
        S_IHI   = 18'h00400,
        S_ICAP  = 18'h00800,
        S_IACC  = 18'h01000,
        S_DLOAD = 18'h02000,
        S_DIV   = 18'h04000,
        S_DCAP  = 18'h08000,
        S_TOT   = 18'h10000,
        S_RES   = 18'h20000
    } state_t;

    localparam logic [STEP_CNT_W-1:0] SQRT_LAST = STEP_CNT_W'(SQRT_STEPS - 1);
    localparam logic [STEP_CNT_W-1:0] DIV_LAST  = STEP_CNT_W'(DIV_STEPS - 1);
    localparam logic [95:0] CAP96 = 96'd1 << 60;
    localparam logic [63:0] CAP64 = 64'd1 << 60;

    state_t                  state_reg, state_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    dkp_job_t                job_reg, job_next;
    logic [65:0]             prod_reg;
    logic [32:0]             mul_a, mul_b;
    logic [63:0]             acc_reg, acc_next;
    logic [63:0]             rad_reg, rad_next;
    logic [33:0]             rem_reg, rem_next;
    logic [31:0]             root_reg, root_next;
    logic signed [31:0]      err_reg, err_next;
    logic signed [63:0]      p_reg, p_next;
    logic [63:0]             m1_reg, m1_next;
    logic                    sgn_reg, sgn_next;
    logic [60:0]             imag_reg, imag_next;
    logic signed [63:0]      d_reg, d_next;
    logic signed [31:0]      tot_reg, tot_next;
    logic                    stop_reg, stop_next;
    logic                    noel_reg, noel_next;
    logic signed [31:0]      integ_reg, integ_next;
    logic signed [31:0]      last_err_reg, last_err_next;
    logic                    ovalid_reg, ovalid_next;
    logic [31:0]             othr_reg, othr_next;
    logic                    ostop_reg, ostop_next;
    logic                    onoel_reg, onoel_next;

    logic [64:0]             sq_sum;
    logic [35:0]             sq_sh, sq_trial, sq_diff;
    logic signed [33:0]      dist_err;
    logic signed [32:0]      e_sum, e_diff;
    logic [95:0]             inc_full, inc_shift;
    logic signed [63:0]      inc_s, integ_w, ceil_w, floor_w, tot_w;
    logic [32:0]             div_sh, div_sub;
    logic                    div_ge;
    logic [65:0]             p_shift, m1_shift;
    logic                    out_free;

    assign out_free      = !ovalid_reg || m_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = othr_reg;
    assign m_axis_tuser  = {onoel_reg, ostop_reg};

    // Datapath helpers shared by the states below.
    always_comb
    begin
        sq_sum    = {1'b0, acc_reg} + {1'b0, prod_reg[63:0]};
        sq_sh     = {rem_reg, rad_reg[63:62]};
        sq_trial  = {2'b00, root_reg, 2'b01};
        sq_diff   = sq_sh - sq_trial;
        dist_err  = $signed({2'b00, root_reg}) - $signed({3'b000, cfg.keep});
        e_sum     = {err_reg[31], err_reg} + {last_err_reg[31], last_err_reg};
        e_diff    = {err_reg[31], err_reg} - {last_err_reg[31], last_err_reg};
        p_shift   = prod_reg >> FRAC_BITS;
        m1_shift  = prod_reg >> (FRAC_BITS + 1);
        inc_full  = {32'd0, acc_reg} + {prod_reg[63:0], 32'd0};
        inc_shift = inc_full >> FRAC_BITS;
        inc_s     = sgn_reg ? -$signed({3'b000, imag_reg}) : $signed({3'b000, imag_reg});
        integ_w   = inc_s + {{32{integ_reg[31]}}, integ_reg};
        ceil_w    = {{32{cfg.ceil_lim[31]}}, cfg.ceil_lim};
        floor_w   = {{32{cfg.floor_lim[31]}}, cfg.floor_lim};
        div_sh    = {rem_reg[31:0], rad_reg[63]};
        div_sub   = div_sh - {1'b0, job_reg.dt};
        div_ge    = (div_sh >= {1'b0, job_reg.dt});
        tot_w     = p_reg + {{32{integ_reg[31]}}, integ_reg} + d_reg
                    - {{32{job_reg.speed[31]}}, job_reg.speed};
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        job_next      = job_reg;
        acc_next      = acc_reg;
        rad_next      = rad_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        err_next      = err_reg;
        p_next        = p_reg;
        m1_next       = m1_reg;
        sgn_next      = sgn_reg;
        imag_next     = imag_reg;
        d_next        = d_reg;
        tot_next      = tot_reg;
        stop_next     = stop_reg;
        noel_next     = noel_reg;
        integ_next    = integ_reg;
        last_err_next = last_err_reg;
        ovalid_next   = ovalid_reg && !m_axis_tready;
        othr_next     = othr_reg;
        ostop_next    = ostop_reg;
        onoel_next    = onoel_reg;
        mul_a         = '0;
        mul_b         = '0;
        pop           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    job_next   = queue_job;
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                mul_a      = mag33(job_reg.dx);
                mul_b      = mag33(job_reg.dx);
                state_next = S_SQY;
            end
            S_SQY:
            begin
                mul_a      = mag33(job_reg.dy);
                mul_b      = mag33(job_reg.dy);
                acc_next   = prod_reg[63:0];
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // A sum past 64 bits means a distance of 2^32 or more.
                if (sq_sum[64])
                begin
                    err_next   = S32_MAX;
                    state_next = S_BAND;
                end
                else
                begin
                    rad_next   = sq_sum[63:0];
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                // One result bit of the square root per cycle.
                rad_next = {rad_reg[61:0], 2'b00};
                if (sq_sh >= sq_trial)
                begin
                    rem_next  = sq_diff[33:0];
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_sh[33:0];
                    root_next = {root_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                err_next   = (dist_err > 34'sh0_7FFF_FFFF) ? S32_MAX : dist_err[31:0];
                state_next = S_BAND;
            end
            S_BAND:
            begin
                // Inside the stop band the controller resets and stops the car.
                if ((err_reg > 0) && (err_reg < $signed({1'b0, cfg.band})))
                begin
                    integ_next = '0;
                    stop_next  = 1'b1;
                    noel_next  = 1'b0;
                    tot_next   = '0;
                    state_next = S_RES;
                end
                else
                begin
                    mul_a      = {1'b0, mag32(cfg.kp)};
                    mul_b      = {1'b0, mag32(err_reg)};
                    sgn_next   = cfg.kp[31] ^ err_reg[31];
                    stop_next  = 1'b0;
                    state_next = S_PMUL;
                end
            end
            S_PMUL:
            begin
                p_next     = sgn_reg ? -$signed(p_shift[63:0]) : $signed(p_shift[63:0]);
                mul_a      = {1'b0, mag32(cfg.ki)};
                mul_b      = mag33(e_sum);
                sgn_next   = cfg.ki[31] ^ e_sum[32];
                state_next = S_IMUL;
            end
            S_IMUL:
            begin
                m1_next    = m1_shift[63:0];
                state_next = S_ILO;
            end
            S_ILO:
            begin
                mul_a      = {1'b0, m1_reg[31:0]};
                mul_b      = {1'b0, job_reg.dt};
                state_next = S_IHI;
            end
            S_IHI:
            begin
                acc_next   = prod_reg[63:0];
                mul_a      = {1'b0, m1_reg[63:32]};
                mul_b      = {1'b0, job_reg.dt};
                state_next = S_ICAP;
            end
            S_ICAP:
            begin
                imag_next  = (inc_shift > CAP96) ? CAP96[60:0] : inc_shift[60:0];
                state_next = S_IACC;
            end
            S_IACC:
            begin
                // Ceiling is tested before floor.
                if (integ_w > ceil_w)
                begin
                    integ_next = cfg.ceil_lim;
                end
                else if (integ_w < floor_w)
                begin
                    integ_next = cfg.floor_lim;
                end
                else
                begin
                    integ_next = integ_w[31:0];
                end
                mul_a    = {1'b0, mag32(cfg.kd)};
                mul_b    = mag33(e_diff);
                sgn_next = cfg.kd[31] ^ e_diff[32];
                if (job_reg.dt == '0)
                begin
                    d_next     = '0;
                    noel_next  = 1'b1;
                    state_next = S_TOT;
                end
                else
                begin
                    noel_next  = 1'b0;
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                rad_next   = prod_reg[63:0];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                rem_next = {2'b00, div_ge ? div_sub[31:0] : div_sh[31:0]};
                rad_next = {rad_reg[62:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DCAP;
                end
            end
            S_DCAP:
            begin
                if (rad_reg > CAP64)
                begin
                    d_next = sgn_reg ? -$signed(CAP64) : $signed(CAP64);
                end
                else
                begin
                    d_next = sgn_reg ? -$signed(rad_reg) : $signed(rad_reg);
                end
                state_next = S_TOT;
            end
            S_TOT:
            begin
                if (tot_w > 64'sh0000_0000_7FFF_FFFF)
                begin
                    tot_next = S32_MAX;
                end
                else if (tot_w < -64'sh0000_0000_8000_0000)
                begin
                    tot_next = S32_MIN;
                end
                else
                begin
                    tot_next = tot_w[31:0];
                end
                state_next = S_RES;
            end
            S_RES:
            begin
                // Wait for the output register, then retire the job.
                if (out_free)
                begin
                    ovalid_next   = 1'b1;
                    othr_next     = tot_reg;
                    ostop_next    = stop_reg;
                    onoel_next    = noel_reg;
                    last_err_next = stop_reg ? '0 : err_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            integ_reg    <= '0;
            last_err_reg <= '0;
            ovalid_reg   <= 1'b0;
            stop_reg     <= 1'b0;
            noel_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            integ_reg    <= integ_next;
            last_err_reg <= last_err_next;
            ovalid_reg   <= ovalid_next;
            stop_reg     <= stop_next;
            noel_reg     <= noel_next;
        end
    end

    // Working registers and the shared multiplier.
    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        job_reg   <= job_next;
        acc_reg   <= acc_next;
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        err_reg   <= err_next;
        p_reg     <= p_next;
        m1_reg    <= m1_next;
        sgn_reg   <= sgn_next;
        imag_reg  <= imag_next;
        d_reg     <= d_next;
        tot_reg   <= tot_next;
        othr_reg  <= othr_next;
        ostop_reg <= ostop_next;
        onoel_reg <= onoel_next;
    end

    // A stop result carries zero throttle.
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && ostop_reg) |-> (othr_reg == '0))
        else $error("stop result with nonzero throttle");

    // Stop and zero elapsed time never come together.
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !(ostop_reg && onoel_reg))
        else $error("stopped and no_elapsed both set");

    // Retiring a job stores its error, or zero after a stop.
    a_last_err: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RES && out_free) |=>
            (last_err_reg == ($past(stop_reg) ? 32'sd0 : $past(err_reg))))
        else $error("previous error not updated on retire");

    // With ordered limits the integrator stays inside them after an update.
    a_integ_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IACC && cfg.floor_lim <= cfg.ceil_lim) |=>
            (integ_reg <= cfg.ceil_lim && integ_reg >= cfg.floor_lim))
        else $error("integrator outside its limits");

endmodule

>>> tb/tb.sv
// Testbench of the distance-keeping PID controller: directed table, random words, self-check.
`timescale 1ns / 1ps

module tb;
    import dkp_pkg::*;

    localparam int FRAC = 16;
    localparam logic [63:0] MAG_CAP = 64'h1 << 60;
    localparam int N_RANDOM = 900;
    localparam int N_PHASES = 6;

    // One expected output word.
    typedef struct packed {
        logic [31:0] throttle;
        logic        stopped;
        logic        no_elapsed;
    } throttle_word_t;

    // One row of the directed table.
    typedef struct packed {
        logic        kind;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] speed;
        logic [31:0] dt;
        logic        typed;
        logic [31:0] t_throttle;
        logic        t_stopped;
        logic        t_no_elapsed;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Configuration copy and controller state of the predictor.
    longint kp_q, ki_q, kd_q, floor_q, ceil_q, keep_q, band_q;
    longint veh_x, veh_y, veh_speed, integ_acc, prev_err;

    throttle_word_t pending_words[$];
    int mismatches = 0;
    int words_checked = 0;
    int stop_words = 0;
    int zero_dt_words = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int phase_no = 0;
    bit long_hold_done = 1'b0;
    int hold_left = 0;

    distance_keeping_pid_controller uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Global limit on the run.
    initial
    begin
        #40ms;
        $display("Timeout with %0d words still expected.", pending_words.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint sign_ext(input logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Signed product shifted right, truncated on magnitudes and capped.
    function automatic longint fixed_mul(input longint a, input longint b, input int sh);
        logic [127:0] prod;
        logic [63:0] m;
        prod = 128'(magnitude(a)) * 128'(magnitude(b));
        prod = prod >> sh;
        m = (prod > 128'(MAG_CAP)) ? MAG_CAP : prod[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    // Integer square root, rounded down.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'h1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Control step for a target word; updates the integrator and previous error.
    function automatic throttle_word_t control_step(input logic [31:0] tx,
                                                    input logic [31:0] ty,
                                                    input logic [31:0] dt);
        throttle_word_t w;
        logic [63:0] ax, ay, q;
        logic [64:0] sum;
        longint err, p, integ, d, diff;
        ax = magnitude(sign_ext(tx) - veh_x);
        ay = magnitude(sign_ext(ty) - veh_y);
        sum = 65'(ax * ax) + 65'(ay * ay);
        if (sum[64])
            err = 64'sd2147483647;
        else
            err = clip32(longint'(floor_sqrt(sum[63:0])) - keep_q);
        if (err > 0 && err < band_q)
        begin
            integ_acc = 0;
            prev_err = 0;
            w.throttle = '0;
            w.stopped = 1'b1;
            w.no_elapsed = 1'b0;
            return w;
        end
        p = fixed_mul(kp_q, err, FRAC);
        integ = fixed_mul(fixed_mul(ki_q, err + prev_err, FRAC + 1), longint'({32'd0, dt}), FRAC);
        integ = integ + integ_acc;
        if (integ > ceil_q)
            integ = ceil_q;
        else if (integ < floor_q)
            integ = floor_q;
        integ_acc = integ;
        d = 0;
        if (dt != 0)
        begin
            diff = err - prev_err;
            q = (magnitude(kd_q) * magnitude(diff)) / {32'd0, dt};
            if (q > MAG_CAP)
                q = MAG_CAP;
            d = ((kd_q < 0) != (diff < 0)) ? -longint'(q) : longint'(q);
        end
        w.throttle = 32'(clip32(p + integ + d - veh_speed));
        w.stopped = 1'b0;
        w.no_elapsed = (dt == 0);
        prev_err = err;
        return w;
    endfunction

    // Register write: setup cycle, then access cycle.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = CFG_ADDR_W'({idx, 2'b00});
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic load_config(input logic [31:0] kp, input logic [31:0] ki,
                               input logic [31:0] kd, input logic [31:0] fl,
                               input logic [31:0] ce, input logic [30:0] keep,
                               input logic [30:0] band);
        reg_write(REG_KP, kp);
        reg_write(REG_KI, ki);
        reg_write(REG_KD, kd);
        reg_write(REG_FLOOR, fl);
        reg_write(REG_CEIL, ce);
        reg_write(REG_KEEP, {1'b0, keep});
        reg_write(REG_BAND, {1'b0, band});
        kp_q = sign_ext(kp);
        ki_q = sign_ext(ki);
        kd_q = sign_ext(kd);
        floor_q = sign_ext(fl);
        ceil_q = sign_ext(ce);
        keep_q = longint'(keep);
        band_q = longint'(band);
    endtask

    // Offer one input word and predict on acceptance. A typed expectation overrides.
    task automatic send_word(input logic kind, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] spd, input logic [31:0] dt,
                             input logic typed, input throttle_word_t typed_word);
        throttle_word_t w;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = kind;
        s_axis_tdata = {dt, spd, y, x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (kind == KIND_ODOMETRY)
        begin
            veh_x = sign_ext(x);
            veh_y = sign_ext(y);
            veh_speed = sign_ext(spd);
        end
        else
        begin
            w = control_step(x, y, dt);
            pending_words.push_back(typed ? typed_word : w);
        end
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid = 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_near(input longint base);
        return 32'(base + longint'($urandom_range(0, 2097152)) - 64'sd1048576);
    endfunction

    // Receiver: random back-pressure plus one long hold-off.
    always @(negedge clk)
    begin
        if (phase_no == 1 && !long_hold_done)
        begin
            long_hold_done = 1'b1;
            hold_left = 600;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Output checker.
    always @(posedge clk)
    begin
        throttle_word_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected word: throttle %h flags %b", m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                exp_w = pending_words.pop_front();
                words_checked++;
                if (exp_w.stopped)
                    stop_words++;
                if (exp_w.no_elapsed)
                    zero_dt_words++;
                if (m_axis_tdata !== exp_w.throttle || m_axis_tuser[0] !== exp_w.stopped
                    || m_axis_tuser[1] !== exp_w.no_elapsed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: throttle %h/%h stopped %b/%b no_elapsed %b/%b",
                                 exp_w.throttle, m_axis_tdata, exp_w.stopped,
                                 m_axis_tuser[0], exp_w.no_elapsed, m_axis_tuser[1]);
                end
            end
        end
    end

    // Stimulus.
    initial
    begin
        row_t dir_tab[14];
        throttle_word_t tw;
        logic kind;
        logic [31:0] x, y, spd, dt;
        int r;
        kp_q = sign_ext(KP_RESET);
        ki_q = sign_ext(KI_RESET);
        kd_q = sign_ext(KD_RESET);
        floor_q = sign_ext(FLOOR_RESET);
        ceil_q = sign_ext(CEIL_RESET);
        keep_q = longint'(KEEP_RESET);
        band_q = longint'(BAND_RESET);
        veh_x = 0;
        veh_y = 0;
        veh_speed = 0;
        integ_acc = 0;
        prev_err = 0;
        dir_tab = '{
            // Stop band straight after reset.
            '{1'b1, 32'd134349, 32'd0, 32'd0, 32'd65536, 1'b1, 32'd0, 1'b1, 1'b0},
            '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0},
            // Error exactly zero, then zero elapsed time.
            '{1'b1, 32'd131072, 32'd0, 32'hFFFF_FFFF, 32'd65536, 1'b1, 32'd0, 1'b0, 1'b0},
            '{1'b1, 32'd131072, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0, 1'b1},
            '{1'b1, 32'd0, 32'd0, 32'd0, 32'd65536, 1'b0, 32'd0, 1'b0, 1'b0},
            // Extreme corners: huge distance saturates the error.
            '{1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              1'b0, 32'd0, 1'b0, 1'b0},
            '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
              1'b0, 32'd0, 1'b0, 1'b0},
            '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0},
            '{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd0,
              1'b0, 32'd0, 1'b0, 1'b0},
            '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5, 32'd1, 1'b0, 32'd0, 1'b0, 1'b0},
            '{1'b1, 32'h7FFF_FFFF, 32'h8000_0001, 32'd0, 32'd1, 1'b0, 32'd0, 1'b0, 1'b0},
            '{1'b0, 32'd65536, 32'hFFFF_0000, 32'h0001_8000, 32'd7, 1'b0, 32'd0, 1'b0, 1'b0},
            '{1'b1, 32'd327680, 32'hFFFF_0000, 32'd0, 32'd6554, 1'b0, 32'd0, 1'b0, 1'b0},
            '{1'b1, 32'hFFF0_0000, 32'h0010_0000, 32'd0, 32'd1, 1'b0, 32'd0, 1'b0, 1'b0}
        };
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table with default registers.
        send_idle_pct = 24;
        recv_idle_pct = 57;
        foreach (dir_tab[i])
        begin
            tw.throttle = dir_tab[i].t_throttle;
            tw.stopped = dir_tab[i].t_stopped;
            tw.no_elapsed = dir_tab[i].t_no_elapsed;
            send_word(dir_tab[i].kind, dir_tab[i].x, dir_tab[i].y, dir_tab[i].speed,
                      dir_tab[i].dt, dir_tab[i].typed, tw);
        end

        // Random phases, each with its own register setting and one of three idling modes.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain_and_settle();
            case (ph)
                1: load_config($urandom, $urandom, $urandom, $urandom, $urandom,
                               31'($urandom_range(0, 1 << 20)),
                               31'($urandom_range(0, 1 << 18)));
                2: load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 31'd0, 31'h7FFF_FFFF);
                3: load_config(32'(196608 + $urandom_range(0, 65535)), 32'd3277, 32'd13107,
                               -32'sd19661, 32'd131072, 31'($urandom_range(0, 1 << 19)),
                               31'($urandom_range(2, 1 << 16)));
                4: load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                               32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0);
                5: load_config(32'($urandom_range(0, 1 << 20)), 32'($urandom_range(0, 1 << 14)),
                               32'($urandom_range(0, 1 << 16)), 32'hFFFF_0000, 32'h0002_0000,
                               31'($urandom_range(0, 1 << 18)), 31'($urandom_range(2, 1 << 15)));
                default: ;
            endcase
            phase_no = ph;
            send_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 57 : 0;
            recv_idle_pct = (ph < 2) ? 57 : (ph < 4) ? 24 : 0;
            for (int n = 0; n < N_RANDOM / N_PHASES; n++)
            begin
                r = $urandom_range(0, 9);
                kind = (r < 3) ? KIND_ODOMETRY : KIND_TARGET;
                spd = ($urandom_range(0, 3) == 0) ? $urandom
                                                  : 32'($urandom_range(0, 1 << 19)) - 32'h0004_0000;
                r = $urandom_range(0, 9);
                if (r < 2)
                begin
                    x = $urandom;
                    y = $urandom;
                end
                else if (r < 5 && kind == KIND_TARGET && band_q >= 2)
                begin
                    // Aim for the stop band.
                    x = 32'(veh_x + keep_q + longint'($urandom_range(1, 32'(band_q - 1))));
                    y = 32'(veh_y);
                end
                else
                begin
                    x = rand_near(veh_x);
                    y = rand_near(veh_y);
                end
                r = $urandom_range(0, 9);
                dt = (r == 0) ? 32'd0 : (r == 1) ? $urandom : 32'($urandom_range(1, 1 << 17));
                send_word(kind, x, y, spd, dt, 1'b0, tw);
            end
        end

        drain_and_settle();
        $display("Checked %0d output words (%0d stopped, %0d with zero elapsed time)",
                 words_checked, stop_words, zero_dt_words);
        $display("over %0d register settings and three idling modes.", N_PHASES);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatches in total.", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> distance_keeping_pid_controller.f
src/dkp_pkg.sv
src/dkp_fifo.sv
src/dkp_front.sv
src/dkp_back.sv
src/distance_keeping_pid_controller.sv
tb/tb.sv
